[rtl/assert_macros.svh]
// Shared assertion forms for the deque RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("deque invariant violated");

// Check that a condition holds in the same cycle as its trigger.
`define ASSERT_IMPLIES(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("deque same-cycle check failed");

// Check that a condition holds in the cycle after its trigger.
`define ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("deque next-cycle check failed");

`endif

[rtl/cdq_pkg.sv]
package cdq_pkg;

  localparam int DEPTH_DEFAULT = 8;

  // Operation codes carried in the kind field
  localparam logic [2:0] KIND_INS_REAR  = 3'd0;
  localparam logic [2:0] KIND_INS_FRONT = 3'd1;
  localparam logic [2:0] KIND_DEL_FRONT = 3'd2;
  localparam logic [2:0] KIND_DEL_REAR  = 3'd3;
  localparam logic [2:0] KIND_QUERY     = 3'd4;

  // Result status codes
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] front_value;
    logic signed [31:0] rear_value;
    logic [3:0]         element_count;
    logic               is_empty;
    logic               is_full;
  } rsp_t;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic        shift_in;   // insert at front: every cell takes its left neighbour
    logic        shift_out;  // delete at front: every cell takes its right neighbour
    logic        load_rear;  // insert at rear: the cell just past the rear takes value
    logic [31:0] value;
  } cell_ctrl_t;

endpackage

[rtl/cdq_cell.sv]
module cdq_cell
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int IDX   = 0,
  localparam int CntW = $clog2(DEPTH + 1)
) (
  input  logic            clk,
  input  cell_ctrl_t      ctrl,
  input  logic [CntW-1:0] count,
  input  logic [31:0]     left,
  input  logic [31:0]     right,
  output logic [31:0]     data,
  output logic [31:0]     tap
);

  logic is_next_free;
  logic is_last;

  // Locate this cell against the current fill level
  assign is_next_free = (count == CntW'(IDX));
  assign is_last      = (count == CntW'(IDX + 1));

  // Shift towards the rear, shift towards the front, or take a rear insert
  always_ff @(posedge clk) begin
    if (ctrl.shift_in) begin
      data <= left;
    end else if (ctrl.shift_out) begin
      data <= right;
    end else if (ctrl.load_rear && is_next_free) begin
      data <= ctrl.value;
    end
  end

  // Offer the word only when this cell holds the rear element
  assign tap = is_last ? data : '0;

endmodule

[rtl/circular_double_ended_queue.sv]
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_ready  | req_t: kind, value
// rsp     | out       | rsp_valid/rsp_ready  | rsp_t: status, front/rear, count, flags
//
// For each item, the row of cells shifts or loads on acceptance, then the rear
// word is picked from the cell taps into the output register.
// One item is in flight at a time; the next is taken as the result leaves.
// rsp_valid holds while rsp_ready is low, and req_ready stays low meanwhile.
// Synchronous reset empties the deque; cell contents are not cleared.
module circular_double_ended_queue
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int CntW = $clog2(DEPTH + 1)
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

`include "assert_macros.svh"

  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  logic [1:0]      status_q;
  logic [1:0]      status_next;
  logic            pend;
  logic            accept;
  logic            full;
  logic            empty;
  logic            ins_rear;
  logic            ins_front;
  logic            del_front;
  logic            del_rear;
  cell_ctrl_t      ctrl;
  logic [31:0]     cell_data [DEPTH];
  logic [31:0]     cell_tap  [DEPTH];
  logic [31:0]     rear_word;
  logic            out_free;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = !pend && out_free;
  assign accept    = req_valid && req_ready;

  assign full  = (count == CntW'(DEPTH));
  assign empty = (count == '0);

  // Decode the operation and reject it against the current fill level
  always_comb begin
    ins_rear    = 1'b0;
    ins_front   = 1'b0;
    del_front   = 1'b0;
    del_rear    = 1'b0;
    status_next = STATUS_DONE;
    case (req.kind)
      KIND_INS_REAR: begin
        if (full) status_next = STATUS_FULL;
        else      ins_rear = 1'b1;
      end
      KIND_INS_FRONT: begin
        if (full) status_next = STATUS_FULL;
        else      ins_front = 1'b1;
      end
      KIND_DEL_FRONT: begin
        if (empty) status_next = STATUS_EMPTY;
        else       del_front = 1'b1;
      end
      KIND_DEL_REAR: begin
        if (empty) status_next = STATUS_EMPTY;
        else       del_rear = 1'b1;
      end
      default: begin
        status_next = STATUS_DONE;
      end
    endcase
  end

  // Advance the fill level
  always_comb begin
    count_next = count;
    if (ins_rear || ins_front) begin
      count_next = count + CntW'(1);
    end else if (del_front || del_rear) begin
      count_next = count - CntW'(1);
    end
  end

  // Broadcast the command to the row
  always_comb begin
    ctrl.shift_in  = accept && ins_front;
    ctrl.shift_out = accept && del_front;
    ctrl.load_rear = accept && ins_rear;
    ctrl.value     = req.value;
  end

  // Row of cells, front element in cell zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [31:0] left_in;
    logic [31:0] right_in;
    if (i == 0) begin : g_head
      assign left_in = ctrl.value;
    end else begin : g_body
      assign left_in = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign right_in = '0;
    end else begin : g_inner
      assign right_in = cell_data[i+1];
    end
    cdq_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .count (count),
      .left  (left_in),
      .right (right_in),
      .data  (cell_data[i]),
      .tap   (cell_tap[i])
    );
  end

  // Merge the taps: only the rear cell drives a non-zero word
  always_comb begin
    rear_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_word = rear_word | cell_tap[i];
    end
  end

  // Hold fill level, status and the in-flight flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pend  <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
        pend  <= 1'b1;
      end else if (pend && out_free) begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_q <= status_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (pend && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend && out_free) begin
      rsp.status        <= status_q;
      rsp.front_value   <= empty ? '1 : cell_data[0];
      rsp.rear_value    <= empty ? '1 : rear_word;
      rsp.element_count <= 4'(count);
      rsp.is_empty      <= empty;
      rsp.is_full       <= full;
    end
  end

  `ASSERT_ALWAYS(a_count_range, clk, rst, count <= CntW'(DEPTH))
  `ASSERT_NEXT(a_accept_pends, clk, rst, accept, pend && !req_ready)
  `ASSERT_IMPLIES(a_one_in_flight, clk, rst, pend, !req_ready)
  `ASSERT_IMPLIES(a_rsp_empty_count, clk, rst, rsp_valid && rsp.is_empty,
                  rsp.element_count == 4'd0 && rsp.front_value == -32'sd1)

endmodule
